>>> rtl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants of the range presence detector: command and
// mode codes, register indexes, reset values and the stats result record.
// ----------------------------------------------------------------------------
package rpd_pkg;

    // data widths
    localparam int DIST_W = 13;
    localparam int MODE_W = 3;
    localparam int CMD_W  = 2;
    localparam int CNT_W  = 4;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // default window depth
    localparam int WINDOW_DEF = 16;

    // largest distance value, starting point of the minimum search
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACT     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEACT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SNS_RDY = 2'd3;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MEASURE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_AWAIT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PRESENT = 3'd4;

    // register indexes (word address)
    localparam logic [2:0] REG_RAW_LIMIT   = 3'd0;
    localparam logic [2:0] REG_MEAN_LOW    = 3'd1;
    localparam logic [2:0] REG_MEAN_HIGH   = 3'd2;
    localparam logic [2:0] REG_MAX_SPREAD  = 3'd3;
    localparam logic [2:0] REG_DROP_MARGIN = 3'd4;
    localparam logic [2:0] REG_CONFIRM     = 3'd5;

    // register reset values
    localparam logic [DIST_W-1:0] RAW_LIMIT_RST   = 13'd500;
    localparam logic [DIST_W-1:0] MEAN_LOW_RST    = 13'd100;
    localparam logic [DIST_W-1:0] MEAN_HIGH_RST   = 13'd600;
    localparam logic [DIST_W-1:0] MAX_SPREAD_RST  = 13'd20;
    localparam logic [DIST_W-1:0] DROP_MARGIN_RST = 13'd50;
    localparam logic [CNT_W-1:0]  CONFIRM_RST     = 4'd8;

    // window statistics handed back after a walk
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] mean;
        logic [DIST_W-1:0] spread;
    } t_stats;

endpackage

>>> rtl/rpd_window.sv
// ----------------------------------------------------------------------------
// rpd_window
// Sample window memory with a walker that reads every entry once and
// accumulates sum, minimum and maximum, then forms the mean.
// ----------------------------------------------------------------------------
module rpd_window #(
    parameter int WINDOW = rpd_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [$clog2(WINDOW)-1:0]   i_wr_addr,
    input  logic [rpd_pkg::DIST_W-1:0]  i_wr_data,
    input  logic                        i_start,
    output rpd_pkg::t_stats             o_stats
);
    import rpd_pkg::*;

    localparam int AW   = $clog2(WINDOW);
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int SW   = DIST_W + AW;
    localparam bit POW2 = ((1 << AW) == WINDOW);

    // reciprocal of the window depth, exact for every sum below 2**SW
    localparam int RS = SW + AW;
    localparam int KW = SW + 1;
    localparam int PW = SW + KW;
    localparam logic [KW-1:0] RECIP = KW'(((longint'(1) << RS) + WINDOW - 1) / WINDOW);

    localparam logic [CW-1:0] CNT_FULL = CW'(WINDOW);
    localparam logic [CW-1:0] CNT_LAST = CW'(WINDOW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [DIST_W-1:0]  mem [WINDOW];
    logic [DIST_W-1:0]  r_rd_data;
    logic               r_data_vld;
    logic [CW-1:0]      r_issued;
    logic [CW-1:0]      r_rcvd;
    logic [SW-1:0]      r_sum;
    logic [DIST_W-1:0]  r_min;
    logic [DIST_W-1:0]  r_max;
    logic               r_done;
    logic [DIST_W-1:0]  r_mean;
    logic [DIST_W-1:0]  r_spread;

    logic               w_rd_en;
    logic [PW-1:0]      w_prod;

    // one read per cycle until every entry has been issued
    assign w_rd_en = (r_state == S_WALK) && (r_issued != CNT_FULL);

    // sum times the reciprocal of the window depth
    assign w_prod = PW'(r_sum) * PW'(RECIP);

    // window storage, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_issued[AW-1:0]];
        end
    end

    // walk sequencer and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_data_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_data_vld <= w_rd_en;
            r_done     <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_issued <= '0;
                        r_rcvd   <= '0;
                        r_sum    <= '0;
                        r_min    <= DIST_MAX;
                        r_max    <= '0;
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_rd_en) begin
                        r_issued <= r_issued + 1'b1;
                    end
                    if (r_data_vld) begin
                        r_sum  <= r_sum + {{AW{1'b0}}, r_rd_data};
                        r_rcvd <= r_rcvd + 1'b1;
                        if (r_rd_data < r_min) begin
                            r_min <= r_rd_data;
                        end
                        if (r_rd_data > r_max) begin
                            r_max <= r_rd_data;
                        end
                        if (r_rcvd == CNT_LAST) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_spread <= r_max - r_min;
                    if (POW2) begin
                        r_mean <= r_sum[SW-1 -: DIST_W];
                    end else begin
                        r_mean <= w_prod[RS +: DIST_W];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stats.done   = r_done;
    assign o_stats.mean   = r_mean;
    assign o_stats.spread = r_spread;

endmodule

>>> rtl/range_presence_detector_unit.sv
// ----------------------------------------------------------------------------
// range_presence_detector_unit
// Follows a distance sensor through its modes, builds a baseline from a
// window of readings and declares presence on a run of short readings.
//
// channel   direction  signals
// -------   ---------  ------------------------------------------------------
// event     in         i_in_valid, o_in_ready, i_cmd, i_distance_mm,
//                      i_sensor_timeout
// result    out        o_out_valid, i_out_ready, o_mode, o_mode_changed,
//                      o_baseline_mean, o_reading_rejected
// config    in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Most events finish in the cycle of their transfer; the result is registered
// and valid on the next cycle.
// A reading taken into a full window starts a walk over the window memory:
// its result is loaded once the walk has read every entry, one memory read per
// cycle, and has formed the mean and spread.
// Synchronous active-low reset; the window memory is not cleared.
// A new event is taken while no walk runs and the result register is free or
// being drained in the same cycle.
// ----------------------------------------------------------------------------
module range_presence_detector_unit #(
    parameter int WINDOW = rpd_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // event channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rpd_pkg::CMD_W-1:0]   i_cmd,
    input  logic [rpd_pkg::DIST_W-1:0]  i_distance_mm,
    input  logic                        i_sensor_timeout,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rpd_pkg::MODE_W-1:0]  o_mode,
    output logic                        o_mode_changed,
    output logic [rpd_pkg::DIST_W-1:0]  o_baseline_mean,
    output logic                        o_reading_rejected,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpd_pkg::ADDR_W-1:0]  paddr,
    input  logic [rpd_pkg::DATA_W-1:0]  pwdata,
    output logic [rpd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import rpd_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);

    localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW);

    typedef enum logic {
        S_READY,
        S_BUSY
    } t_state;

    // configuration registers
    logic [DIST_W-1:0] r_raw_limit;
    logic [DIST_W-1:0] r_mean_low;
    logic [DIST_W-1:0] r_mean_high;
    logic [DIST_W-1:0] r_max_spread;
    logic [DIST_W-1:0] r_drop_margin;
    logic [CNT_W-1:0]  r_confirm;

    // block state
    t_state            r_state;
    logic [MODE_W-1:0] r_mode;
    logic [AW-1:0]     r_slot;
    logic [FW-1:0]     r_fill;
    logic [DIST_W-1:0] r_mean;
    logic [CNT_W-1:0]  r_low_run;

    // result register
    logic              r_out_valid;
    logic [MODE_W-1:0] r_out_mode;
    logic              r_out_changed;
    logic [DIST_W-1:0] r_out_mean;
    logic              r_out_rejected;

    // next values for an accepted event
    logic [MODE_W-1:0] n_mode;
    logic [AW-1:0]     n_slot;
    logic [FW-1:0]     n_fill;
    logic [DIST_W-1:0] n_mean;
    logic [CNT_W-1:0]  n_low_run;
    logic              n_changed;
    logic              n_rejected;
    logic              n_wr_en;
    logic              n_start;

    logic              w_in_xfer;
    logic              w_out_xfer;
    logic              w_cfg_wr;
    logic              w_low;
    logic              w_baseline;
    t_stats            w_stats;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = r_out_valid && i_out_ready;
    assign o_in_ready = (r_state == S_READY) && (!r_out_valid || i_out_ready);
    assign w_cfg_wr   = psel && penable && pwrite;
    assign pready     = 1'b1;

    // reading well below the baseline mean
    assign w_low = ({1'b0, i_distance_mm} + {1'b0, r_drop_margin}) < {1'b0, r_mean};

    // stable baseline check on walk results
    assign w_baseline = (w_stats.mean > r_mean_low) && (w_stats.mean < r_mean_high)
                        && (w_stats.spread < r_max_spread);

    // event decode
    always_comb begin
        n_mode     = r_mode;
        n_slot     = r_slot;
        n_fill     = r_fill;
        n_mean     = r_mean;
        n_low_run  = r_low_run;
        n_changed  = 1'b0;
        n_rejected = 1'b0;
        n_wr_en    = 1'b0;
        n_start    = 1'b0;
        case (i_cmd)
            CMD_ACT: begin
                if (r_mode == MODE_IDLE) begin
                    n_mode    = MODE_MEASURE;
                    n_changed = 1'b1;
                end
            end
            CMD_DEACT: begin
                if (r_mode != MODE_INIT) begin
                    n_mode    = MODE_IDLE;
                    n_changed = 1'b1;
                end
            end
            CMD_SNS_RDY: begin
                if (r_mode == MODE_INIT) begin
                    n_mode = MODE_IDLE;
                end
            end
            CMD_TICK: begin
                if (i_sensor_timeout) begin
                    n_mean    = '0;
                    n_fill    = '0;
                    n_mode    = MODE_INIT;
                    n_changed = 1'b1;
                end else if (r_mode == MODE_MEASURE) begin
                    if (i_distance_mm > r_raw_limit) begin
                        n_mean     = '0;
                        n_fill     = '0;
                        n_rejected = 1'b1;
                    end else begin
                        n_wr_en = 1'b1;
                        n_slot  = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                        if (r_fill < FILL_FULL) begin
                            n_fill = r_fill + 1'b1;
                        end else begin
                            n_start = 1'b1;
                        end
                    end
                end else if (r_mode == MODE_AWAIT) begin
                    if (w_low) begin
                        if (r_low_run < r_confirm) begin
                            n_low_run = r_low_run + 1'b1;
                            if ((r_low_run + 1'b1) == r_confirm) begin
                                n_mode    = MODE_PRESENT;
                                n_changed = 1'b1;
                            end
                        end
                    end else begin
                        n_low_run = '0;
                    end
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    // window memory and statistics walker
    rpd_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_in_xfer && n_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (i_distance_mm),
        .i_start   (w_in_xfer && n_start),
        .o_stats   (w_stats)
    );

    // control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READY;
            r_mode      <= MODE_INIT;
            r_slot      <= '0;
            r_fill      <= '0;
            r_mean      <= '0;
            r_low_run   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_READY: begin
                    if (w_out_xfer) begin
                        r_out_valid <= 1'b0;
                    end
                    if (w_in_xfer) begin
                        r_mode    <= n_mode;
                        r_slot    <= n_slot;
                        r_fill    <= n_fill;
                        r_mean    <= n_mean;
                        r_low_run <= n_low_run;
                        if (n_start) begin
                            r_state <= S_BUSY;
                        end else begin
                            r_out_valid    <= 1'b1;
                            r_out_mode     <= n_mode;
                            r_out_changed  <= n_changed;
                            r_out_mean     <= n_mean;
                            r_out_rejected <= n_rejected;
                        end
                    end
                end
                S_BUSY: begin
                    if (w_stats.done) begin
                        r_mean         <= w_stats.mean;
                        r_out_valid    <= 1'b1;
                        r_out_mean     <= w_stats.mean;
                        r_out_rejected <= 1'b0;
                        r_out_changed  <= w_baseline;
                        r_out_mode     <= w_baseline ? MODE_AWAIT : r_mode;
                        if (w_baseline) begin
                            r_mode <= MODE_AWAIT;
                        end
                        r_state <= S_READY;
                    end
                end
                default: begin
                    r_state <= S_READY;
                end
            endcase
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_limit   <= RAW_LIMIT_RST;
            r_mean_low    <= MEAN_LOW_RST;
            r_mean_high   <= MEAN_HIGH_RST;
            r_max_spread  <= MAX_SPREAD_RST;
            r_drop_margin <= DROP_MARGIN_RST;
            r_confirm     <= CONFIRM_RST;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_RAW_LIMIT:   r_raw_limit   <= pwdata[DIST_W-1:0];
                REG_MEAN_LOW:    r_mean_low    <= pwdata[DIST_W-1:0];
                REG_MEAN_HIGH:   r_mean_high   <= pwdata[DIST_W-1:0];
                REG_MAX_SPREAD:  r_max_spread  <= pwdata[DIST_W-1:0];
                REG_DROP_MARGIN: r_drop_margin <= pwdata[DIST_W-1:0];
                REG_CONFIRM:     r_confirm     <= pwdata[CNT_W-1:0];
                default: begin
                    r_confirm <= r_confirm;
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[4:2])
            REG_RAW_LIMIT:   prdata = {{(DATA_W-DIST_W){1'b0}}, r_raw_limit};
            REG_MEAN_LOW:    prdata = {{(DATA_W-DIST_W){1'b0}}, r_mean_low};
            REG_MEAN_HIGH:   prdata = {{(DATA_W-DIST_W){1'b0}}, r_mean_high};
            REG_MAX_SPREAD:  prdata = {{(DATA_W-DIST_W){1'b0}}, r_max_spread};
            REG_DROP_MARGIN: prdata = {{(DATA_W-DIST_W){1'b0}}, r_drop_margin};
            REG_CONFIRM:     prdata = {{(DATA_W-CNT_W){1'b0}}, r_confirm};
            default:         prdata = '0;
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_mode             = r_out_mode;
    assign o_mode_changed     = r_out_changed;
    assign o_baseline_mean    = r_out_mean;
    assign o_reading_rejected = r_out_rejected;

    // walk results only arrive while a walk is outstanding
    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stats.done |-> (r_state == S_BUSY))
        else $error("window stats returned with no walk outstanding");

    // a walk result never lands on an undelivered result
    a_out_free_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stats.done |-> !r_out_valid)
        else $error("result register still occupied when walk finished");

    // fill count never passes the window depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond window depth");

    // a started walk holds off new events until its result is out
    a_walk_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && n_start) |=> !o_in_ready)
        else $error("event accepted while a walk was running");

endmodule

>>> tb/range_presence_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_presence_detector_unit_tb
// Drives sensor events into the presence detector and compares each result
// with a cycle-free predictor of modes, baseline window and low-reading run.
// Register settings change between phases, from the reset values to open and
// closed extremes and random values, while both channels idle and stall.
// ----------------------------------------------------------------------------
module range_presence_detector_unit_tb;

    import rpd_pkg::*;

    localparam int WIN        = WINDOW_DEF;
    localparam int SETTLE     = WIN + 24;
    localparam int CYCLE_CAP  = 400000;

    // one result record of the detector
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              changed;
        logic [DIST_W-1:0] mean;
        logic              rejected;
    } t_report;

    // ------------------------------------------------------------------------
    // predictor of the detector and store of the reports still to come
    // ------------------------------------------------------------------------
    class presence_tracker;
        // register copies
        logic [DIST_W-1:0] raw_limit, mean_low, mean_high, max_spread, drop_margin;
        logic [CNT_W-1:0]  confirm;
        // detector state
        logic [MODE_W-1:0]      mode;
        logic [DIST_W-1:0]      readings [WIN];
        logic [$clog2(WIN)-1:0] slot;
        logic [$clog2(WIN):0]   fill;
        logic [DIST_W-1:0]      mean_mm;
        logic [CNT_W-1:0]       low_run;
        t_report awaited_reports [$];
        // run statistics
        int failures, events, checked, baselines, presences, rejects, timeouts;

        function new();
            raw_limit   = RAW_LIMIT_RST;
            mean_low    = MEAN_LOW_RST;
            mean_high   = MEAN_HIGH_RST;
            max_spread  = MAX_SPREAD_RST;
            drop_margin = DROP_MARGIN_RST;
            confirm     = CONFIRM_RST;
            mode        = MODE_INIT;
            slot        = '0;
            fill        = '0;
            mean_mm     = '0;
            low_run     = '0;
            foreach (readings[k]) readings[k] = '0;
        endfunction

        function void set_register(logic [2:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_RAW_LIMIT:   raw_limit   = value[DIST_W-1:0];
                REG_MEAN_LOW:    mean_low    = value[DIST_W-1:0];
                REG_MEAN_HIGH:   mean_high   = value[DIST_W-1:0];
                REG_MAX_SPREAD:  max_spread  = value[DIST_W-1:0];
                REG_DROP_MARGIN: drop_margin = value[DIST_W-1:0];
                REG_CONFIRM:     confirm     = value[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the state by one accepted event and queue its report
        function void take_event(logic [CMD_W-1:0] cmd, logic [DIST_W-1:0] dist_mm,
                                 logic tmo);
            t_report r;
            int sum, lo, hi, k;
            r.changed  = 1'b0;
            r.rejected = 1'b0;
            events++;
            case (cmd)
                CMD_ACT: begin
                    if (mode == MODE_IDLE) begin
                        mode = MODE_MEASURE;
                        r.changed = 1'b1;
                    end
                end
                CMD_DEACT: begin
                    if (mode != MODE_INIT) begin
                        mode = MODE_IDLE;
                        r.changed = 1'b1;
                    end
                end
                CMD_SNS_RDY: begin
                    // leaves init silently
                    if (mode == MODE_INIT) mode = MODE_IDLE;
                end
                default: begin
                    if (tmo) begin
                        mean_mm = '0;
                        fill = '0;
                        mode = MODE_INIT;
                        r.changed = 1'b1;
                        timeouts++;
                    end else if (mode == MODE_MEASURE) begin
                        if (dist_mm > raw_limit) begin
                            // restart the window fill
                            mean_mm = '0;
                            fill = '0;
                            r.rejected = 1'b1;
                            rejects++;
                        end else begin
                            readings[slot] = dist_mm;
                            slot = slot + 1'b1;
                            if (fill < WIN) begin
                                fill = fill + 1'b1;
                            end else begin
                                // statistics over the full window
                                sum = 0;
                                lo = DIST_MAX;
                                hi = 0;
                                for (k = 0; k < WIN; k++) begin
                                    sum += readings[k];
                                    if (readings[k] < lo) lo = readings[k];
                                    if (readings[k] > hi) hi = readings[k];
                                end
                                mean_mm = DIST_W'(sum / WIN);
                                if (mean_mm > mean_low && mean_mm < mean_high &&
                                    (hi - lo) < max_spread) begin
                                    mode = MODE_AWAIT;
                                    r.changed = 1'b1;
                                    baselines++;
                                end
                            end
                        end
                    end else if (mode == MODE_AWAIT) begin
                        if ({1'b0, dist_mm} + {1'b0, drop_margin} < {1'b0, mean_mm}) begin
                            // saturated run waits for a reading that is not low
                            if (low_run < confirm) begin
                                low_run = low_run + 1'b1;
                                if (low_run == confirm) begin
                                    mode = MODE_PRESENT;
                                    r.changed = 1'b1;
                                    presences++;
                                end
                            end
                        end else begin
                            low_run = '0;
                        end
                    end
                end
            endcase
            r.mode = mode;
            r.mean = mean_mm;
            awaited_reports.push_back(r);
        endfunction

        // compare one transfer on the result channel with the oldest report
        function void check_report(t_report got);
            t_report want;
            if (awaited_reports.size() == 0) begin
                $error("result transfer with no report awaited: mode %0d mean %0d",
                       got.mode, got.mean);
                failures++;
                return;
            end
            want = awaited_reports.pop_front();
            checked++;
            if (got.mode !== want.mode) begin
                $error("mode: expected %0d, got %0d", want.mode, got.mode);
                failures++;
            end
            if (got.changed !== want.changed) begin
                $error("mode_changed: expected %0d, got %0d", want.changed, got.changed);
                failures++;
            end
            if (got.mean !== want.mean) begin
                $error("baseline_mean: expected %0d, got %0d", want.mean, got.mean);
                failures++;
            end
            if (got.rejected !== want.rejected) begin
                $error("reading_rejected: expected %0d, got %0d", want.rejected,
                       got.rejected);
                failures++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_cmd;
    logic [DIST_W-1:0]    i_distance_mm;
    logic                 i_sensor_timeout;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [MODE_W-1:0]    o_mode;
    logic                 o_mode_changed;
    logic [DIST_W-1:0]    o_baseline_mean;
    logic                 o_reading_rejected;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    presence_tracker tracker = new();
    int cycle_count = 0;
    int burst_left  = 0;
    int center_mm   = 0;
    int jitter_mm   = 0;
    int phases      = 0;

    range_presence_detector_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_distance_mm      (i_distance_mm),
        .i_sensor_timeout   (i_sensor_timeout),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_mode             (o_mode),
        .o_mode_changed     (o_mode_changed),
        .o_baseline_mean    (o_baseline_mean),
        .o_reading_rejected (o_reading_rejected),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
                     tracker.awaited_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result channel monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_report({o_mode, o_mode_changed, o_baseline_mean,
                                  o_reading_rejected});
    end

    // receiver stall pattern: runs of steady, random, sparse or periodic ready
    initial begin
        int style, run_len, k;
        i_out_ready = 1'b0;
        k = 0;
        forever begin
            style = $urandom_range(0, 3);
            run_len = $urandom_range(16, 80);
            repeat (run_len) begin
                @(negedge i_clk);
                k++;
                case (style)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = 1'($urandom_range(0, 1));
                    2: i_out_ready = ($urandom_range(0, 3) == 0);
                    default: i_out_ready = (k % 9) >= 3;
                endcase
            end
        end
    end

    // register write in setup and access cycles, then read back
    task automatic write_register(logic [2:0] idx, logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        tracker.set_register(idx, value);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        pwdata = $urandom;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            $error("register %0d readback: expected %0d, got %0d", idx, value, prdata);
            tracker.failures++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_settings(int raw, int lo, int hi, int spread, int drop, int conf);
        write_register(REG_RAW_LIMIT, raw);
        write_register(REG_MEAN_LOW, lo);
        write_register(REG_MEAN_HIGH, hi);
        write_register(REG_MAX_SPREAD, spread);
        write_register(REG_DROP_MARGIN, drop);
        write_register(REG_CONFIRM, conf);
        phases++;
    endtask

    // present one event and hold it until the transfer
    task automatic send_event(logic [CMD_W-1:0] cmd, logic [DIST_W-1:0] dist_mm, logic tmo);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_distance_mm = dist_mm;
        i_sensor_timeout = tmo;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_event(cmd, dist_mm, tmo);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_distance_mm = DIST_W'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // wait for every report, then let a window walk finish before a write
    task automatic drain_reports();
        pause_sender(1);
        while (tracker.awaited_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // pick the next event from the predicted mode, mostly well-formed sequences
    task automatic next_event(output logic [CMD_W-1:0] cmd,
                              output logic [DIST_W-1:0] dist_mm,
                              output logic tmo, output bit counted);
        int r, v, lim, lo_b, hi_b, m, dm;
        r = $urandom_range(0, 99);
        cmd = CMD_TICK;
        tmo = 1'b0;
        counted = 1'b1;
        v = $urandom_range(0, DIST_MAX);
        lim = tracker.raw_limit;
        if (r < 8) begin
            // noise
            cmd = CMD_W'($urandom_range(0, 3));
            tmo = 1'($urandom_range(0, 1));
            counted = 1'b0;
        end else begin
            case (tracker.mode)
                MODE_INIT: begin
                    if (r < 90) cmd = CMD_SNS_RDY;
                    else counted = 1'b0;
                end
                MODE_IDLE: begin
                    cmd = CMD_ACT;
                    // new target level for the coming window
                    lo_b = tracker.mean_low + 1;
                    hi_b = tracker.mean_high - 1;
                    if (hi_b > lim) hi_b = lim;
                    if (lo_b <= hi_b) center_mm = $urandom_range(lo_b, hi_b);
                    else center_mm = $urandom_range(0, lim);
                    if ($urandom_range(0, 4) == 0) jitter_mm = $urandom_range(0, 1000);
                    else if (tracker.max_spread > 1)
                        jitter_mm = $urandom_range(0, (tracker.max_spread > 400) ? 399 :
                                                      tracker.max_spread - 1);
                    else jitter_mm = 0;
                end
                MODE_MEASURE: begin
                    if (r < 10) tmo = 1'b1;
                    else if (r < 13) v = (lim < DIST_MAX) ? lim + 1 : lim;
                    else if (r < 16) v = lim;
                    else if (r < 18) v = 0;
                    else if (r < 20) cmd = CMD_DEACT;
                    else begin
                        v = center_mm + $urandom_range(0, jitter_mm);
                        if (v > lim) v = lim;
                    end
                end
                MODE_AWAIT: begin
                    m = tracker.mean_mm;
                    dm = tracker.drop_margin;
                    if (r < 10) tmo = 1'b1;
                    else if (r >= 95) cmd = CMD_DEACT;
                    else if (r < 80 && m > dm) begin
                        v = m - dm - 1;
                        v = v - $urandom_range(0, (v < 30) ? v : 30);
                    end else begin
                        v = m - dm + $urandom_range(0, 40);
                        if (v < 0) v = 0;
                        if (v > DIST_MAX) v = DIST_MAX;
                    end
                end
                default: begin
                    if (r < 70) cmd = CMD_DEACT;
                    else if (r < 85) tmo = 1'b1;
                    else counted = 1'b0;
                end
            endcase
        end
        dist_mm = DIST_W'(v);
    endtask

    // random events in bursts with gaps between them
    task automatic run_random(int target);
        logic [CMD_W-1:0]  cmd;
        logic [DIST_W-1:0] dist_mm;
        logic              tmo;
        bit                counted;
        int                done;
        done = 0;
        while (done < target) begin
            if (burst_left == 0) begin
                pause_sender($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 10);
            end
            next_event(cmd, dist_mm, tmo, counted);
            send_event(cmd, dist_mm, tmo);
            burst_left--;
            if (counted) done++;
        end
    endtask

    // stimulus
    initial begin
        int p, lo;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = CMD_TICK;
        i_distance_mm = '0;
        i_sensor_timeout = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed events at reset settings
        send_event(CMD_TICK, DIST_MAX, 1'b0);     // tick in init, no effect
        send_event(CMD_ACT, 13'd0, 1'b0);         // activate outside await activation
        send_event(CMD_DEACT, 13'd0, 1'b0);       // deactivate in init
        send_event(CMD_TICK, 13'd0, 1'b1);        // timeout while already init
        send_event(CMD_SNS_RDY, 13'd0, 1'b0);     // silent exit from init
        send_event(CMD_SNS_RDY, 13'd77, 1'b0);    // sensor ready elsewhere ignored
        send_event(CMD_TICK, 13'd4096, 1'b0);     // tick while awaiting activation
        send_event(CMD_DEACT, 13'd0, 1'b0);       // broadcast though mode unchanged
        send_event(CMD_ACT, 13'd0, 1'b0);
        send_event(CMD_ACT, 13'd0, 1'b0);         // activate while measuring
        send_event(CMD_TICK, 13'd501, 1'b0);      // just above the raw limit
        send_event(CMD_TICK, 13'd500, 1'b0);      // at the raw limit
        send_event(CMD_TICK, 13'd0, 1'b0);
        send_event(CMD_DEACT, 13'd0, 1'b0);       // keeps the partial window
        send_event(CMD_ACT, 13'd0, 1'b0);
        send_event(CMD_TICK, DIST_MAX, 1'b1);     // timeout while measuring
        send_event(CMD_ACT, 13'd0, 1'b0);
        send_event(CMD_SNS_RDY, 13'd0, 1'b0);
        run_random(120);
        phases++;

        // moderate settings, short confirmation
        drain_reports();
        apply_settings(2000, 50, 3000, 60, 120, 3);
        run_random(115);

        // open extremes: everything passes, single low reading confirms
        drain_reports();
        apply_settings(DIST_MAX, 0, DIST_MAX, DIST_MAX, 0, 1);
        run_random(115);

        // closed extremes: nothing forms a baseline, longest confirmation
        drain_reports();
        apply_settings(0, DIST_MAX, 0, 0, DIST_MAX, 15);
        run_random(110);

        // random settings
        for (p = 0; p < 2; p++) begin
            drain_reports();
            lo = $urandom_range(0, 1500);
            apply_settings($urandom_range(200, DIST_MAX), lo, $urandom_range(lo + 2, DIST_MAX),
                           $urandom_range(1, 300), $urandom_range(0, 500),
                           $urandom_range(1, 15));
            run_random(115);
        end

        // wind down
        pause_sender(1);
        while (tracker.awaited_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (tracker.awaited_reports.size() != 0) begin
            $error("%0d reports never arrived", tracker.awaited_reports.size());
            tracker.failures++;
        end
        $display("covered %0d events over %0d register settings, %0d results checked",
                 tracker.events, phases, tracker.checked);
        $display("baselines %0d, presence %0d, rejected readings %0d, timeouts %0d",
                 tracker.baselines, tracker.presences, tracker.rejects, tracker.timeouts);
        if (tracker.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
